@@ rtl/spq_pkg.sv @@
// Package for the sorted priority queue with decrease-key.
// Holds widths, operation and status codes. No dependencies.
package spq_pkg;
  localparam int unsigned CapacityDef = 64;
  localparam int unsigned IdBitsDef   = 16;
  localparam int unsigned PrioBitsDef = 16;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OutIdW  = 16;
  localparam int unsigned OutPrW  = 16;
  localparam int unsigned OccW    = 7;

  typedef enum logic [FuncW-1:0] {
    FN_INSERT  = 2'd0,
    FN_SERVE   = 2'd1,
    FN_UPGRADE = 2'd2,
    FN_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_EMPTY      = 3'd1,
    ST_FULL       = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_NOT_URGENT = 3'd4
  } status_e;

  // Commands from the controller to the cell array.
  typedef struct packed {
    logic insert;
    logic remove_head;
    logic remove_hit;
    logic clear;
  } spq_cmd_t;

  // Status from the cell array to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic found;
    logic urgent;
  } spq_stat_t;
endpackage

@@ rtl/spq_if.sv @@
// Valid/ready channel interface for the priority queue.
// Depends on no package; payload width is a parameter.
interface spq_if #(
  parameter int unsigned W = 8
) (
  input logic clk_i
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/spq_cells.sv @@
// Systolic cell array that holds the sorted entries.
// Depends on spq_pkg for command and status structs.
module spq_cells
  import spq_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned IdBits   = IdBitsDef,
  parameter int unsigned PrioBits = PrioBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spq_cmd_t                      cmd_i,
  input  logic [IdBits-1:0]             id_i,
  input  logic [PrioBits-1:0]           prio_i,
  output spq_stat_t                     stat_o,
  output logic [IdBits-1:0]             head_id_o,
  output logic [PrioBits-1:0]           head_prio_o,
  output logic [$clog2(Capacity+1)-1:0] count_o
);
  localparam int unsigned CntW = $clog2(Capacity+1);

  logic [IdBits-1:0]   id_q   [Capacity];
  logic [PrioBits-1:0] prio_q [Capacity];
  logic [Capacity-1:0] vld_q;
  logic [CntW-1:0]     cnt_q;
  logic [Capacity-1:0] hit, first_hit, before_hit, le;
  logic [Capacity-1:0] hit_urgent;

  // Per-cell compares; the first matching id is found by a prefix chain.
  always_comb begin
    for (int k = 0; k < Capacity; k++) begin
      hit[k] = vld_q[k] && (id_q[k] == id_i);
      le[k]  = vld_q[k] && (prio_q[k] <= prio_i);
      hit_urgent[k] = prio_q[k] > prio_i;
    end
    before_hit[0] = 1'b0;
    for (int k = 1; k < Capacity; k++) before_hit[k] = before_hit[k-1] | hit[k-1];
    first_hit = hit & ~before_hit;
  end

  assign stat_o.empty  = !vld_q[0];
  assign stat_o.full   = vld_q[Capacity-1];
  assign stat_o.found  = |first_hit;
  assign stat_o.urgent = |(first_hit & hit_urgent);
  assign head_id_o     = id_q[0];
  assign head_prio_o   = prio_q[0];
  assign count_o       = cnt_q;

  // Valid bits and entry count: insert fills the next free cell; removals shift down.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.clear) begin
      vld_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.insert) begin
      vld_q <= {vld_q[Capacity-2:0], 1'b1};
      cnt_q <= cnt_q + CntW'(1);
    end else if (cmd_i.remove_head || cmd_i.remove_hit) begin
      vld_q <= {1'b0, vld_q[Capacity-1:1]};
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Entry data: insert shifts up behind the placement point; removal closes the gap.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Capacity; k++) begin
      if (cmd_i.insert) begin
        if (!le[k]) begin
          if (k == 0 || le[(k==0)?0:k-1]) begin
            id_q[k]   <= id_i;
            prio_q[k] <= prio_i;
          end else begin
            id_q[k]   <= id_q[(k==0)?0:k-1];
            prio_q[k] <= prio_q[(k==0)?0:k-1];
          end
        end
      end else if ((cmd_i.remove_head || (cmd_i.remove_hit && (first_hit[k] || before_hit[k])))
                   && k < Capacity-1) begin
        id_q[k]   <= id_q[(k<Capacity-1)?k+1:k];
        prio_q[k] <= prio_q[(k<Capacity-1)?k+1:k];
      end
    end
  end
endmodule

@@ rtl/spq_ctrl.sv @@
// Controller: decodes an operation, issues cell commands, builds the result.
// Depends on spq_pkg for codes and command/status structs.
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned IdBits   = IdBitsDef,
  parameter int unsigned PrioBits = PrioBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [FuncW-1:0]              func_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output spq_cmd_t                      cmd_o,
  input  spq_stat_t                     stat_i,
  input  logic [IdBits-1:0]             head_id_i,
  input  logic [PrioBits-1:0]           head_prio_i,
  input  logic [$clog2(Capacity+1)-1:0] count_i,
  output logic [StatusW-1:0]            status_o,
  output logic [OutIdW-1:0]             served_o,
  output logic                          front_valid_o,
  output logic [OutIdW-1:0]             front_id_o,
  output logic [OutPrW-1:0]             front_prio_o,
  output logic [OccW-1:0]               occ_o
);
  typedef enum logic [1:0] {S_IDLE, S_REINS, S_REPORT} state_e;
  state_e state_q;
  logic [StatusW-1:0] status_q;
  logic [OutIdW-1:0]  served_q;
  logic               out_valid_q;
  logic               take;
  func_e              fn;

  assign fn         = func_e'(func_i);
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign take       = in_valid_i && in_ready_o;

  // Cell commands for the accepted operation.
  always_comb begin
    cmd_o = '0;
    if (state_q == S_REINS) begin
      cmd_o.insert = 1'b1;
    end else if (take) begin
      unique case (fn)
        FN_INSERT:  cmd_o.insert      = !stat_i.full;
        FN_SERVE:   cmd_o.remove_head = !stat_i.empty;
        FN_UPGRADE: cmd_o.remove_hit  = stat_i.found && stat_i.urgent;
        FN_CLEAR:   cmd_o.clear       = 1'b1;
        default:    cmd_o = '0;
      endcase
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      served_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (take) begin
          served_q <= '0;
          status_q <= ST_OK;
          state_q  <= S_REPORT;
          unique case (fn)
            FN_INSERT: if (stat_i.full) status_q <= ST_FULL;
            FN_SERVE:
              if (stat_i.empty) status_q <= ST_EMPTY;
              else served_q <= OutIdW'(head_id_i);
            FN_UPGRADE:
              if (stat_i.empty) status_q <= ST_EMPTY;
              else if (!stat_i.found) status_q <= ST_NOT_FOUND;
              else if (!stat_i.urgent) status_q <= ST_NOT_URGENT;
              else state_q <= S_REINS;
            default: status_q <= ST_OK;
          endcase
        end
        S_REINS: state_q <= S_REPORT;
        S_REPORT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Front and count are read live; the cells hold still until the next transfer.
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign served_o      = served_q;
  assign front_valid_o = !stat_i.empty;
  assign front_id_o    = stat_i.empty ? '0 : OutIdW'(head_id_i);
  assign front_prio_o  = stat_i.empty ? '0 : OutPrW'(head_prio_i);
  assign occ_o         = OccW'(count_i);
endmodule

@@ rtl/sorted_priority_queue_decrease_key_top.sv @@
// Top level of the sorted priority queue with decrease-key.
// Depends on spq_pkg, spq_if, spq_ctrl and spq_cells.
//
//  channel | direction | payload
//  in_ch   | sink      | func, entry_id, entry_priority
//  out_ch  | source    | status, served_id, front_valid, front_id,
//          |           |   front_priority, occupancy
//
// Insert, serve and clear go through S_REPORT before the result is valid; an
// accepted upgrade passes S_REINS first (remove in the cell array, then re-insert).
// The next input is taken the cycle after the result has been transferred,
// so a new operation is never accepted while a result is pending.
// Reset clears all valid bits and the count at once; no clearing pass is needed.
// A stalled result holds; the queue is frozen while it waits.
module sorted_priority_queue_decrease_key_top
  import spq_pkg::*;
#(
  parameter int unsigned Capacity = CapacityDef,
  parameter int unsigned IdBits   = IdBitsDef,
  parameter int unsigned PrioBits = PrioBitsDef
) (
  input logic   clk_i,
  input logic   rst_ni,
  spq_if.sink   in_ch,
  spq_if.source out_ch
);
  localparam int unsigned CntW = $clog2(Capacity+1);

  spq_cmd_t            cmd;
  spq_stat_t           stat;
  logic [IdBits-1:0]   head_id, id_in;
  logic [PrioBits-1:0] head_prio, prio_in;
  logic [CntW-1:0]     count;
  logic [StatusW-1:0]  status;
  logic [OutIdW-1:0]   served, front_id;
  logic [OutPrW-1:0]   front_prio;
  logic                front_valid;
  logic [OccW-1:0]     occ;
  logic [IdBits-1:0]   id_hold_q;
  logic [PrioBits-1:0] prio_hold_q;

  // Hold the operands for the re-insert step of an upgrade.
  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      id_hold_q   <= in_ch.data[IdBits+PrioBits-1 -: IdBits];
      prio_hold_q <= in_ch.data[PrioBits-1:0];
    end
  end

  assign id_in   = cmd.insert && !in_ch.ready ? id_hold_q
                 : in_ch.data[IdBits+PrioBits-1 -: IdBits];
  assign prio_in = cmd.insert && !in_ch.ready ? prio_hold_q
                 : in_ch.data[PrioBits-1:0];

  spq_cells #(.Capacity(Capacity), .IdBits(IdBits), .PrioBits(PrioBits)) u_cells (
    .clk_i, .rst_ni, .cmd_i(cmd), .id_i(id_in), .prio_i(prio_in), .stat_o(stat),
    .head_id_o(head_id), .head_prio_o(head_prio), .count_o(count)
  );

  spq_ctrl #(.Capacity(Capacity), .IdBits(IdBits), .PrioBits(PrioBits)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .func_i(in_ch.data[FuncW+IdBits+PrioBits-1 -: FuncW]),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .cmd_o(cmd), .stat_i(stat), .head_id_i(head_id), .head_prio_i(head_prio),
    .count_i(count), .status_o(status), .served_o(served),
    .front_valid_o(front_valid), .front_id_o(front_id), .front_prio_o(front_prio),
    .occ_o(occ)
  );

  assign out_ch.data = {status, served, front_valid, front_id, front_prio, occ};
endmodule
